FILE: design/dsha_pkg.sv
package dsha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] chain_t;
  typedef word_t [15:0] block_t;

  typedef enum logic [2:0] {
    REG_MID_01  = 3'd0,
    REG_MID_23  = 3'd1,
    REG_MID_45  = 3'd2,
    REG_MID_67  = 3'd3,
    REG_TAIL_01 = 3'd4,
    REG_TAIL_2  = 3'd5
  } reg_idx_e;

  localparam int unsigned NumRounds = 64;

  localparam word_t PadWord   = 32'h8000_0000;
  localparam word_t LenFirst  = 32'h0000_0280;
  localparam word_t LenSecond = 32'h0000_0100;

  localparam word_t RoundK [NumRounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t big_sig0(word_t a);
    return rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic word_t big_sig1(word_t e);
    return rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t y);
    return rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    return (a & b) | (c & (a | b));
  endfunction

  function automatic word_t byte_swap(word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: design/dsha_pipe.sv
module dsha_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  dsha_pkg::block_t block_i,
  input  dsha_pkg::chain_t chain_i,
  output logic             valid_o,
  output dsha_pkg::chain_t digest_o
);

  localparam int unsigned Rounds = dsha_pkg::NumRounds;

  // Stage 0 holds the loaded block, stages 1..Rounds the round outputs,
  // the last bit the chained digest.
  logic [Rounds+1:0] vld_q;
  dsha_pkg::chain_t  st_q  [Rounds+1];
  dsha_pkg::block_t  win_q [Rounds];
  dsha_pkg::chain_t  dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Rounds:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= chain_i;
      win_q[0] <= block_i;
    end
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    dsha_pkg::chain_t st_d;
    dsha_pkg::word_t  t1;
    dsha_pkg::word_t  t2;

    always_comb begin
      t1 = st_q[r][7] + dsha_pkg::big_sig1(st_q[r][4])
         + dsha_pkg::choose(st_q[r][4], st_q[r][5], st_q[r][6])
         + dsha_pkg::RoundK[r] + win_q[r][0];
      t2 = dsha_pkg::big_sig0(st_q[r][0])
         + dsha_pkg::majority(st_q[r][0], st_q[r][1], st_q[r][2]);
      st_d[7] = st_q[r][6];
      st_d[6] = st_q[r][5];
      st_d[5] = st_q[r][4];
      st_d[4] = st_q[r][3] + t1;
      st_d[3] = st_q[r][2];
      st_d[2] = st_q[r][1];
      st_d[1] = st_q[r][0];
      st_d[0] = t1 + t2;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[r+1] <= st_d;
      end
    end

    if (r < Rounds - 1) begin : g_sched
      dsha_pkg::block_t win_d;

      // Slide the schedule window and append the next word.
      always_comb begin
        for (int j = 0; j < 15; j++) begin
          win_d[j] = win_q[r][j+1];
        end
        win_d[15] = dsha_pkg::small_sig1(win_q[r][14]) + win_q[r][9]
                  + dsha_pkg::small_sig0(win_q[r][1]) + win_q[r][0];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          win_q[r+1] <= win_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 8; i++) begin
        dig_q[i] <= st_q[Rounds][i] + chain_i[i];
      end
    end
  end

  assign valid_o  = vld_q[Rounds+1];
  assign digest_o = dig_q;

endmodule

FILE: design/double_sha256_midstate_hash_top.sv
// Double SHA-256 of an 80-byte header resumed from a midstate, one nonce per beat.
// out_valid_o rises once the accepted nonce beat has passed through two unrolled
// 64-round compressions, each with a load stage and a chaining stage.
// Throughput: one nonce per cycle; a stalled output beat freezes the whole pipeline.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and the six
// configuration registers to zero; payload registers are not reset.
module double_sha256_midstate_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] nonce_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_0_o,
  output logic [31:0] digest_word_1_o,
  output logic [31:0] digest_word_2_o,
  output logic [31:0] digest_word_3_o,
  output logic [31:0] digest_word_4_o,
  output logic [31:0] digest_word_5_o,
  output logic [31:0] digest_word_6_o,
  output logic [31:0] digest_word_7_o
);

  // ---------------------------------------------------------------------
  // Configuration registers. Each register sits at 8*index; bits [2:0] of
  // the address are ignored and writes past the last register are dropped.
  // ---------------------------------------------------------------------
  logic [63:0] mid_q [4];
  logic [63:0] tail01_q;
  logic [31:0] tail2_q;
  logic        cfg_wr;
  dsha_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dsha_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        mid_q[i] <= '0;
      end
      tail01_q <= '0;
      tail2_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dsha_pkg::REG_MID_01:  mid_q[0] <= pwdata;
        dsha_pkg::REG_MID_23:  mid_q[1] <= pwdata;
        dsha_pkg::REG_MID_45:  mid_q[2] <= pwdata;
        dsha_pkg::REG_MID_67:  mid_q[3] <= pwdata;
        dsha_pkg::REG_TAIL_01: tail01_q <= pwdata;
        dsha_pkg::REG_TAIL_2:  tail2_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsha_pkg::REG_MID_01:  prdata = mid_q[0];
      dsha_pkg::REG_MID_23:  prdata = mid_q[1];
      dsha_pkg::REG_MID_45:  prdata = mid_q[2];
      dsha_pkg::REG_MID_67:  prdata = mid_q[3];
      dsha_pkg::REG_TAIL_01: prdata = tail01_q;
      dsha_pkg::REG_TAIL_2:  prdata = {32'h0, tail2_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: the pipeline advances as one unit unless the final
  // beat is held by the consumer. Bubbles travel with their valid bits.
  // ---------------------------------------------------------------------
  logic adv;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------
  // First compression: header tail plus byte-swapped nonce, padded to a
  // 640-bit message, chained from the midstate.
  // ---------------------------------------------------------------------
  dsha_pkg::block_t blk1;
  dsha_pkg::chain_t mid_chain;
  dsha_pkg::chain_t mid_digest;
  logic             mid_valid;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mid_chain[2*i]   = mid_q[i][63:32];
      mid_chain[2*i+1] = mid_q[i][31:0];
    end
    blk1     = '0;
    blk1[0]  = tail01_q[63:32];
    blk1[1]  = tail01_q[31:0];
    blk1[2]  = tail2_q;
    blk1[3]  = dsha_pkg::byte_swap(nonce_i);
    blk1[4]  = dsha_pkg::PadWord;
    blk1[15] = dsha_pkg::LenFirst;
  end

  dsha_pipe u_first (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_valid_i),
    .block_i  (blk1),
    .chain_i  (mid_chain),
    .valid_o  (mid_valid),
    .digest_o (mid_digest)
  );

  // ---------------------------------------------------------------------
  // Second compression: the 256-bit digest padded to one block, chained
  // from the standard initial hash values.
  // ---------------------------------------------------------------------
  dsha_pkg::block_t blk2;
  dsha_pkg::chain_t iv_chain;
  dsha_pkg::chain_t fin_digest;

  always_comb begin
    blk2 = '0;
    for (int i = 0; i < 8; i++) begin
      blk2[i]     = mid_digest[i];
      iv_chain[i] = dsha_pkg::InitHash[i];
    end
    blk2[8]  = dsha_pkg::PadWord;
    blk2[15] = dsha_pkg::LenSecond;
  end

  dsha_pipe u_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (mid_valid),
    .block_i  (blk2),
    .chain_i  (iv_chain),
    .valid_o  (out_valid_o),
    .digest_o (fin_digest)
  );

  assign digest_word_0_o = fin_digest[0];
  assign digest_word_1_o = fin_digest[1];
  assign digest_word_2_o = fin_digest[2];
  assign digest_word_3_o = fin_digest[3];
  assign digest_word_4_o = fin_digest[4];
  assign digest_word_5_o = fin_digest[5];
  assign digest_word_6_o = fin_digest[6];
  assign digest_word_7_o = fin_digest[7];

`ifndef SYNTH
  // A frozen pipeline must hold the beat between the two compressions.
  a_mid_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(mid_valid))
    else $error("mid-pipeline valid changed while frozen");

  a_mid_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && mid_valid |=> $stable(mid_digest))
    else $error("mid-pipeline digest changed while frozen");

  // Input is refused only while a finished beat waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output beat");

  // A taken output beat always lets the pipeline advance.
  a_take_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> $past(adv))
    else $error("pipeline froze on a taken output beat");
`endif

endmodule
